/* hdl/hsa_pkg.sv */
package hsa_pkg;

    localparam int PERIOD_DEPTH_DEF = 8;
    localparam int PER_W            = 33;   // signed period in the window
    localparam int CFG_AW           = 3;
    localparam int CFG_DW           = 32;
    localparam int IN_DW            = 56;
    localparam int OUT_DW           = 80;

    // register index
    localparam logic [CFG_AW-1:0] R_HALL_OFFSET = 3'd0;
    localparam logic [CFG_AW-1:0] R_MIN_PERIOD  = 3'd1;
    localparam logic [CFG_AW-1:0] R_MAX_PERIOD  = 3'd2;
    localparam logic [CFG_AW-1:0] R_DPP_FACTOR  = 3'd3;
    localparam logic [CFG_AW-1:0] R_COMP_DIV    = 3'd4;
    localparam logic [CFG_AW-1:0] R_PWM_FREQ    = 3'd5;
    localparam logic [CFG_AW-1:0] R_POLE_PAIRS  = 3'd6;
    localparam logic [CFG_AW-1:0] R_STALL_TMO   = 3'd7;

    // request kinds
    localparam logic [2:0] K_OVERFLOW = 3'd0;
    localparam logic [2:0] K_EDGE     = 3'd1;
    localparam logic [2:0] K_ANGLE    = 3'd2;
    localparam logic [2:0] K_SPEED    = 3'd3;
    localparam logic [2:0] K_CLEAR    = 3'd4;

    typedef enum logic [1:0] {
        OP_AVG   = 2'd0,
        OP_STEP  = 2'd1,
        OP_CATCH = 2'd2,
        OP_RPM   = 2'd3
    } div_op_t;

    typedef struct packed {
        logic        hit;
        logic        neg;
        logic [15:0] ang;
    } hall_dec_t;

    // sector angle at a transition, with direction
    function automatic hall_dec_t edge_decode(input logic [2:0] cur, input logic [2:0] pre);
        hall_dec_t d;
        d = '0;
        case (cur)
            3'd5: if (pre == 3'd4) d = '{1'b1, 1'b0, 16'd0};
                  else if (pre == 3'd1) d = '{1'b1, 1'b1, 16'd10922};
            3'd1: if (pre == 3'd5) d = '{1'b1, 1'b0, 16'd10922};
                  else if (pre == 3'd3) d = '{1'b1, 1'b1, 16'd21845};
            3'd3: if (pre == 3'd1) d = '{1'b1, 1'b0, 16'd21845};
                  else if (pre == 3'd2) d = '{1'b1, 1'b1, 16'd32767};
            3'd2: if (pre == 3'd3) d = '{1'b1, 1'b0, 16'd32767};
                  else if (pre == 3'd6) d = '{1'b1, 1'b1, 16'd43691};
            3'd6: if (pre == 3'd2) d = '{1'b1, 1'b0, 16'd43691};
                  else if (pre == 3'd4) d = '{1'b1, 1'b1, 16'd54614};
            3'd4: if (pre == 3'd6) d = '{1'b1, 1'b0, 16'd54614};
                  else if (pre == 3'd5) d = '{1'b1, 1'b1, 16'd0};
            default: d = '0;
        endcase
        return d;
    endfunction

    // sector centre used when re-seeding the angle
    function automatic hall_dec_t sector_center(input logic [2:0] cur);
        hall_dec_t d;
        d = '0;
        case (cur)
            3'd5:    d = '{1'b1, 1'b0, 16'd5461};
            3'd1:    d = '{1'b1, 1'b0, 16'd16383};
            3'd3:    d = '{1'b1, 1'b0, 16'd27306};
            3'd2:    d = '{1'b1, 1'b0, 16'd38230};
            3'd6:    d = '{1'b1, 1'b0, 16'd49153};
            3'd4:    d = '{1'b1, 1'b0, 16'd60075};
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

/* hdl/hsa_div.sv */
module hsa_div
    import hsa_pkg::*;
#(
    parameter int DVW = 36,
    parameter int DSW = PER_W
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           done,
    output logic [DVW-1:0] quotient
);

    localparam int CW = $clog2(DVW + 1);

    logic [DVW-1:0] quo_reg;
    logic [DSW:0]   rem_reg;
    logic [DSW-1:0] dsr_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [DSW:0]   rem_sh;
    logic           ge;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg[DSW-1:0], quo_reg[DVW-1]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DVW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            quo_reg <= {quo_reg[DVW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/hall_sensor_angle_speed_core.sv */
// channel   dir  signals                          content
// s_axis    in   tvalid tready tdata[55:0] tuser  hall request, tuser = kind
// m_axis    out  tvalid tready tdata[79:0]        one result per request
// cfg       in   cfg_we cfg_addr cfg_wdata        register write, no read-back
//
// Overflow, angle, clear and unknown requests pass through S_EXEC and S_DONE to the
// output register. A hall edge with a used period divides once (window average by shift)
// on a DVW-bit dividend (DVW = 33 + log2 PERIOD_DEPTH, 36 by default); a zero window
// average skips the divide. An operable speed task divides twice.
// Reset clears estimator and config state; window reads zero via per-entry valid bits.
// s_axis_tready is high only in idle; a stalled result stays in the output register
// while the next request is taken. PERIOD_DEPTH must be a power of two.
module hall_sensor_angle_speed_core
    import hsa_pkg::*;
#(
    parameter int PERIOD_DEPTH = PERIOD_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // hall_bits[2:0], capture_count[18:3], now_ms[50:19],
    // motor_started[51], speed_ref_negative[52], zero fill
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // angle_e[15:0], mech_speed_rpm[31:16], speed_dpp[47:32],
    // direction_negative[48], valid_res[49], error_count[57:50],
    // stall_count[73:58], zero fill
    output logic [OUT_DW-1:0] m_axis_tdata,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    localparam int IDXW  = (PERIOD_DEPTH > 1) ? $clog2(PERIOD_DEPTH) : 1;
    localparam int FILLW = $clog2(PERIOD_DEPTH + 1);
    localparam int TW    = PER_W + IDXW;
    localparam int DVW   = TW;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EXEC = 9'b000000010,
        S_WIN  = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_SPD  = 9'b000010000,
        S_MUL  = 9'b000100000,
        S_RPM  = 9'b001000000,
        S_DONE = 9'b010000000,
        S_SPR  = 9'b100000000
    } state_t;

    // configuration
    logic [15:0] off_reg;
    logic [31:0] minp_reg;
    logic [31:0] maxp_reg;
    logic [30:0] dpp_reg;
    logic [7:0]  cdiv_reg;
    logic [15:0] pwm_reg;
    logic [6:0]  pp_reg;
    logic [15:0] tmo_reg;

    // latched request
    logic [2:0]  kind_reg;
    logic [2:0]  bits_reg;
    logic [15:0] cap_reg;
    logic [31:0] now_reg;
    logic        run_reg;
    logic        negref_reg;

    // estimator state
    state_t                  state_reg;
    logic [2:0]              hall_reg;
    logic                    dir_reg;
    logic [15:0]             meas_reg;
    logic [15:0]             angle_reg;
    logic [15:0]             cu_reg;
    logic [15:0]             ovf_reg;
    logic signed [TW-1:0]    total_reg;
    logic [IDXW-1:0]         idx_reg;
    logic [FILLW-1:0]        fill_reg;
    logic                    first_reg;
    logic signed [15:0]      avg_reg;
    logic [31:0]             last_ms_reg;
    logic                    oper_reg;
    logic [7:0]              err_reg;
    logic [15:0]             stall_reg;
    logic signed [15:0]      rpm_reg;

    // work registers
    logic [31:0]             period_reg;
    logic                    vstart_reg;
    logic signed [32:0]      prod_reg;
    logic [DVW-1:0]          dvd_reg;
    logic [PER_W-1:0]        dsr_reg;
    logic                    dstart_reg;
    logic                    dneg_reg;
    div_op_t                 op_reg;

    logic signed [PER_W-1:0] win_mem [PERIOD_DEPTH];
    logic signed [PER_W-1:0] rd_reg;
    logic [PERIOD_DEPTH-1:0] vld_reg;

    logic                    m_valid_reg;
    logic [OUT_DW-1:0]       m_data_reg;

    logic                    div_done;
    logic [DVW-1:0]          div_q;

    // combinational helpers
    hall_dec_t               edec;
    hall_dec_t               sdec;
    logic                    stall_hit;
    logic                    do_clear;
    logic signed [PER_W-1:0] sp;
    logic signed [PER_W-1:0] old_p;
    logic signed [TW-1:0]    total_new;
    logic [FILLW-1:0]        fill_new;
    logic                    use_last;
    logic [DVW-1:0]          total_mag;
    logic [DVW-1:0]          avg_mag;
    logic [15:0]             delta;
    logic [15:0]             delta_mag;
    logic signed [38:0]      v60;
    logic [38:0]             v_mag;
    logic [15:0]             q_sat;
    logic                    in_acc;

    hsa_div #(
        .DVW (DVW),
        .DSW (PER_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dstart_reg),
        .dividend (dvd_reg),
        .divisor  (dsr_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        edec      = edge_decode(bits_reg, hall_reg);
        sdec      = sector_center(bits_reg);
        stall_hit = run_reg && oper_reg &&
                    ((first_reg && ((now_reg - last_ms_reg) >= {16'd0, tmo_reg})) ||
                     (!negref_reg && (avg_reg < 0)) || (negref_reg && (avg_reg > 0)));
        do_clear  = (state_reg == S_EXEC) &&
                    ((kind_reg == K_CLEAR) || ((kind_reg == K_SPEED) && stall_hit));

        sp        = dir_reg ? -$signed({1'b0, period_reg}) : $signed({1'b0, period_reg});
        old_p     = vld_reg[idx_reg] ? rd_reg : '0;
        total_new = total_reg - TW'(old_p) + TW'(sp);
        fill_new  = (fill_reg == FILLW'(PERIOD_DEPTH)) ? fill_reg : fill_reg + 1'b1;
        use_last  = (fill_new != FILLW'(PERIOD_DEPTH)) || (period_reg >= maxp_reg);
        total_mag = total_new[TW-1] ? DVW'(-total_new) : DVW'(total_new);
        // window average, truncated toward zero
        avg_mag   = total_mag >> IDXW;

        delta     = meas_reg - angle_reg;
        delta_mag = delta[15] ? (16'd0 - delta) : delta;

        v60       = (39'(prod_reg) <<< 6) - (39'(prod_reg) <<< 2);
        v_mag     = v60[38] ? 39'(-v60) : 39'(v60);

        // saturate the signed quotient to 16 bits
        if (dneg_reg)
            q_sat = (div_q > DVW'(32768)) ? 16'h8000 : (16'd0 - div_q[15:0]);
        else
            q_sat = (div_q > DVW'(32767)) ? 16'h7fff : div_q[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg  <= '0;
            minp_reg <= '0;
            maxp_reg <= '0;
            dpp_reg  <= 31'd1;
            cdiv_reg <= 8'd1;
            pwm_reg  <= 16'd16000;
            pp_reg   <= 7'd4;
            tmo_reg  <= 16'd500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                R_HALL_OFFSET: off_reg  <= cfg_wdata[15:0];
                R_MIN_PERIOD:  minp_reg <= cfg_wdata;
                R_MAX_PERIOD:  maxp_reg <= cfg_wdata;
                R_DPP_FACTOR:  dpp_reg  <= cfg_wdata[30:0];
                R_COMP_DIV:    cdiv_reg <= cfg_wdata[7:0];
                R_PWM_FREQ:    pwm_reg  <= cfg_wdata[15:0];
                R_POLE_PAIRS:  pp_reg   <= cfg_wdata[6:0];
                R_STALL_TMO:   tmo_reg  <= cfg_wdata[15:0];
                default:       ;
            endcase
        end
    end

    // period window memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WIN)
            win_mem[idx_reg] <= sp;
        rd_reg <= win_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg   <= s_axis_tuser;
            bits_reg   <= s_axis_tdata[2:0];
            cap_reg    <= s_axis_tdata[18:3];
            now_reg    <= s_axis_tdata[50:19];
            run_reg    <= s_axis_tdata[51];
            negref_reg <= s_axis_tdata[52];
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_axis_tready))
        begin
            m_data_reg <= {6'd0, stall_reg, err_reg,
                           (kind_reg == K_SPEED) ? vstart_reg : oper_reg,
                           dir_reg, avg_reg, rpm_reg, angle_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            hall_reg    <= '0;
            dir_reg     <= 1'b0;
            meas_reg    <= '0;
            angle_reg   <= '0;
            cu_reg      <= '0;
            ovf_reg     <= '0;
            total_reg   <= '0;
            idx_reg     <= '0;
            fill_reg    <= '0;
            first_reg   <= 1'b0;
            avg_reg     <= '0;
            last_ms_reg <= '0;
            oper_reg    <= 1'b1;
            err_reg     <= '0;
            stall_reg   <= '0;
            rpm_reg     <= '0;
            vld_reg     <= '0;
            period_reg  <= '0;
            vstart_reg  <= 1'b0;
            prod_reg    <= '0;
            dvd_reg     <= '0;
            dsr_reg     <= '0;
            dstart_reg  <= 1'b0;
            dneg_reg    <= 1'b0;
            op_reg      <= OP_AVG;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            dstart_reg <= 1'b0;
            if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg  <= S_DONE;
                    vstart_reg <= oper_reg;
                    case (kind_reg)
                        K_OVERFLOW:
                        begin
                            if (ovf_reg != 16'hffff)
                                ovf_reg <= ovf_reg + 1'b1;
                        end
                        K_EDGE:
                        begin
                            hall_reg    <= bits_reg;
                            last_ms_reg <= now_reg;
                            ovf_reg     <= '0;
                            if (edec.hit)
                            begin
                                dir_reg  <= edec.neg;
                                meas_reg <= off_reg + edec.ang;
                            end
                            else if (bits_reg == 3'd0 || bits_reg == 3'd7)
                            begin
                                if (err_reg != 8'hff)
                                    err_reg <= err_reg + 1'b1;
                            end
                            if (!first_reg)
                                first_reg <= 1'b1;
                            else
                            begin
                                period_reg <= {ovf_reg, cap_reg};
                                if ({ovf_reg, cap_reg} >= minp_reg)
                                    state_reg <= S_WIN;
                            end
                        end
                        K_ANGLE:
                        begin
                            if (oper_reg)
                            begin
                                meas_reg  <= meas_reg + avg_reg;
                                angle_reg <= angle_reg + avg_reg + cu_reg;
                            end
                        end
                        K_SPEED:
                        begin
                            if (oper_reg)
                            begin
                                state_reg <= S_SPD;
                                if (stall_hit && stall_reg != 16'hffff)
                                    stall_reg <= stall_reg + 1'b1;
                            end
                        end
                        default: ;
                    endcase

                    if (do_clear)
                    begin
                        ovf_reg     <= '0;
                        cu_reg      <= '0;
                        dir_reg     <= 1'b0;
                        total_reg   <= '0;
                        idx_reg     <= '0;
                        fill_reg    <= '0;
                        first_reg   <= 1'b0;
                        avg_reg     <= '0;
                        vld_reg     <= '0;
                        last_ms_reg <= now_reg;
                        hall_reg    <= bits_reg;
                        if (sdec.hit)
                        begin
                            oper_reg  <= 1'b1;
                            err_reg   <= 8'd0;
                            angle_reg <= off_reg + sdec.ang;
                            meas_reg  <= off_reg + sdec.ang;
                        end
                        else
                        begin
                            oper_reg <= 1'b0;
                            err_reg  <= 8'd1;
                            meas_reg <= angle_reg;
                        end
                    end
                end
                S_WIN:
                begin
                    total_reg        <= total_new;
                    vld_reg[idx_reg] <= 1'b1;
                    idx_reg          <= (idx_reg == IDXW'(PERIOD_DEPTH - 1)) ? '0
                                        : idx_reg + 1'b1;
                    fill_reg         <= fill_new;
                    if (use_last)
                    begin
                        dvd_reg    <= DVW'(dpp_reg);
                        dsr_reg    <= (period_reg == 32'd0) ? PER_W'(1) : PER_W'(period_reg);
                        dneg_reg   <= dir_reg;
                        op_reg     <= OP_STEP;
                        dstart_reg <= 1'b1;
                        state_reg  <= S_DIV;
                    end
                    else if (avg_mag == '0)
                    begin
                        avg_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        dvd_reg    <= DVW'(dpp_reg);
                        dsr_reg    <= PER_W'(avg_mag);
                        dneg_reg   <= total_new[TW-1];
                        op_reg     <= OP_STEP;
                        dstart_reg <= 1'b1;
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        unique case (op_reg)
                            OP_STEP:
                            begin
                                avg_reg   <= q_sat;
                                state_reg <= S_DONE;
                            end
                            OP_CATCH:
                            begin
                                cu_reg    <= dneg_reg ? (16'd0 - div_q[15:0]) : div_q[15:0];
                                state_reg <= S_MUL;
                            end
                            OP_RPM:
                            begin
                                rpm_reg   <= q_sat;
                                state_reg <= S_DONE;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_SPD:
                begin
                    // catch-up: angle error over the compensation divider
                    dvd_reg    <= DVW'(delta_mag);
                    dsr_reg    <= (cdiv_reg == 8'd0) ? PER_W'(1) : PER_W'(cdiv_reg);
                    dneg_reg   <= delta[15];
                    op_reg     <= OP_CATCH;
                    dstart_reg <= 1'b1;
                    state_reg  <= S_DIV;
                end
                S_MUL:
                begin
                    prod_reg  <= avg_reg * $signed({1'b0, pwm_reg});
                    state_reg <= S_RPM;
                end
                S_RPM:
                begin
                    dvd_reg    <= DVW'(v_mag[38:16]);
                    dsr_reg    <= (pp_reg == 7'd0) ? PER_W'(1) : PER_W'(pp_reg);
                    dneg_reg   <= v60[38];
                    op_reg     <= OP_RPM;
                    dstart_reg <= 1'b1;
                    state_reg  <= S_DIV;
                end
                S_DONE:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_SPR:
                begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILLW'(PERIOD_DEPTH))
        else $error("window fill beyond depth");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("request taken while busy");

    a_div_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider done outside divide wait");

    a_inoperable_err: assert property (@(posedge clk) disable iff (!rst_n)
        !oper_reg |-> err_reg != 8'd0)
        else $error("inoperable without error count");
`endif

endmodule

/* dv/tb_hall_sensor_angle_speed_core.sv */
module tb_hall_sensor_angle_speed_core;
    import hsa_pkg::*;

    localparam int CLK_HI      = 6;
    localparam int CLK_LO      = 6;
    localparam int RST_CYCLES  = 11;
    localparam int IDLE_LIMIT  = 6000;
    localparam int DRAIN_WAIT  = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 300;
    localparam int RUN_ITEMS   = 150;
    localparam int N_PHASES    = 6;

    localparam logic [2:0] K_SPARE_LO = 3'd5;
    localparam logic [2:0] K_SPARE_HI = 3'd7;
    localparam logic [2:0] HALL_BAD_LO = 3'd0;
    localparam logic [2:0] HALL_BAD_HI = 3'd7;

    // hall states in forward rotation order, edge angle and sector center per state
    localparam logic [2:0] ROT [6] = '{3'd5, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4};
    localparam int EDGE_ANG [6] = '{0, 10922, 21845, 32767, -21845, -10922};
    localparam int CENTER   [6] = '{5461, 16383, 27306, -27306, -16383, -5461};

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  hall;
        logic [15:0] cap;
        logic [31:0] now_ms;
        logic        started;
        logic        ref_neg;
    } hall_req_t;

    typedef struct {
        logic [15:0] angle_e;
        logic [15:0] rpm;
        logic [15:0] dpp;
        logic        dir_neg;
        logic        valid;
        logic [7:0]  errors;
        logic [15:0] stalls;
    } est_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DW-1:0] s_axis_tdata = '0;
    logic [2:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;

    hall_sensor_angle_speed_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #CLK_HI clk = 1'b1;
        #CLK_LO clk = 1'b0;
    end

    // estimator copy: configuration
    int          est_offset;
    int unsigned est_min_per, est_max_per, est_dpp, est_comp_div;
    int unsigned est_pwm, est_poles, est_stall_tmo;
    // estimator copy: state
    logic [2:0]  est_hall;
    logic        est_dir_neg;
    logic [15:0] est_meas_ang, est_angle, est_catch;
    int unsigned est_ovf;
    longint      est_window [8];
    longint      est_total;
    int unsigned est_widx, est_wfill;
    logic        est_first;
    shortint     est_step;
    logic [31:0] est_last_ms;
    logic        est_oper;
    int unsigned est_errors, est_stalls;
    shortint     est_rpm;

    hall_req_t pending_reqs [$];
    est_out_t  expected_outs [$];
    hall_req_t cur_req;
    int fails = 0;
    int n_reqs = 0;
    int n_outs = 0;
    int n_edges = 0;
    int n_speed = 0;
    int idle_cycles = 0;

    function automatic int hall_pos(input logic [2:0] h);
        for (int i = 0; i < 6; i++)
            if (ROT[i] == h)
                return i;
        return -1;
    endfunction

    function automatic shortint sat16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return shortint'(v);
    endfunction

    function automatic shortint step_of(input longint num, input longint den);
        longint mag;
        longint q;
        mag = den < 0 ? -den : den;
        if (mag == 0)
            return 0;
        q = num / mag;
        return sat16(den < 0 ? -q : q);
    endfunction

    task automatic est_reset();
        est_offset = 0; est_min_per = 0; est_max_per = 0; est_dpp = 1;
        est_comp_div = 1; est_pwm = 16000; est_poles = 4; est_stall_tmo = 500;
        est_hall = '0; est_dir_neg = 1'b0; est_meas_ang = '0; est_angle = '0;
        est_catch = '0; est_ovf = 0; est_total = 0; est_widx = 0; est_wfill = 0;
        foreach (est_window[i])
            est_window[i] = 0;
        est_first = 1'b0; est_step = 0; est_last_ms = '0; est_oper = 1'b1;
        est_errors = 0; est_stalls = 0; est_rpm = 0;
    endtask

    task automatic bump_errors();
        if (est_errors < 255)
            est_errors++;
    endtask

    task automatic reseed(input logic [2:0] bits, input logic [31:0] now);
        int p;
        est_ovf = 0; est_catch = '0; est_dir_neg = 1'b0; est_oper = 1'b1;
        est_errors = 0; est_total = 0; est_widx = 0; est_wfill = 0;
        foreach (est_window[i])
            est_window[i] = 0;
        est_first = 1'b0; est_step = 0; est_last_ms = now;
        est_hall = bits;
        p = hall_pos(bits);
        if (p < 0)
        begin
            est_oper = 1'b0;
            bump_errors();
            est_meas_ang = est_angle;
        end
        else
        begin
            est_angle = 16'(est_offset + CENTER[p]);
            est_meas_ang = est_angle;
        end
    endtask

    task automatic est_edge(input hall_req_t r);
        logic [2:0] pre;
        int p, m, dir;
        logic [31:0] period, p1;
        longint sp, last;
        pre = est_hall;
        est_hall = r.hall;
        est_last_ms = r.now_ms;
        dir = 0;
        m = 0;
        p = hall_pos(r.hall);
        if (p < 0)
            bump_errors();
        else if (pre == ROT[(p + 5) % 6])
        begin
            dir = 1;
            m = EDGE_ANG[p];
        end
        else if (pre == ROT[(p + 1) % 6])
        begin
            dir = -1;
            m = EDGE_ANG[(p + 1) % 6];
        end
        if (dir != 0)
        begin
            est_dir_neg = dir < 0;
            est_meas_ang = 16'(est_offset + m);
        end
        if (!est_first)
            est_first = 1'b1;
        else
        begin
            period = 32'(r.cap) + (est_ovf << 16);
            if (period >= est_min_per)
            begin
                p1 = period != 0 ? period : 32'd1;
                sp = est_dir_neg ? -longint'(period) : longint'(period);
                last = est_dir_neg ? -longint'(p1) : longint'(p1);
                est_total -= est_window[est_widx];
                est_window[est_widx] = sp;
                est_total += sp;
                est_widx = (est_widx + 1) % 8;
                if (est_wfill < 8)
                    est_wfill++;
                if (est_wfill < 8 || period >= est_max_per)
                    est_step = step_of(est_dpp, last);
                else
                    est_step = step_of(est_dpp, est_total / 8);
            end
        end
        est_ovf = 0;
    endtask

    task automatic est_speed(input hall_req_t r);
        int delta;
        longint v;
        if (r.started)
        begin
            if ((est_first && (r.now_ms - est_last_ms) >= est_stall_tmo) ||
                (!r.ref_neg && est_step < 0) || (r.ref_neg && est_step > 0))
            begin
                if (est_stalls < 65535)
                    est_stalls++;
                reseed(r.hall, r.now_ms);
            end
        end
        delta = int'(signed'(16'(est_meas_ang - est_angle)));
        est_catch = 16'(delta / int'(est_comp_div != 0 ? est_comp_div : 1));
        v = longint'(est_step) * longint'(est_pwm) * 60;
        v = v / 65536;
        v = v / longint'(est_poles != 0 ? est_poles : 1);
        est_rpm = sat16(v);
    endtask

    task automatic apply_request(input hall_req_t r);
        est_out_t o;
        logic was_oper;
        was_oper = est_oper;
        case (r.kind)
            K_OVERFLOW: if (est_ovf < 65535) est_ovf++;
            K_EDGE: est_edge(r);
            K_ANGLE:
                if (est_oper)
                begin
                    est_meas_ang = est_meas_ang + 16'(est_step);
                    est_angle = est_angle + 16'(est_step) + est_catch;
                end
            K_SPEED: if (est_oper) est_speed(r);
            K_CLEAR: reseed(r.hall, r.now_ms);
            default: ;
        endcase
        o.angle_e = est_angle;
        o.rpm = 16'(est_rpm);
        o.dpp = 16'(est_step);
        o.dir_neg = est_dir_neg;
        o.valid = r.kind == K_SPEED ? was_oper : est_oper;
        o.errors = 8'(est_errors);
        o.stalls = 16'(est_stalls);
        expected_outs.push_back(o);
        if (r.kind == K_EDGE)
            n_edges++;
        if (r.kind == K_SPEED)
            n_speed++;
    endtask

    task automatic report(input string field, input int got, input int want);
        fails++;
        $display("mismatch on result %0d: %s got %0h expected %0h", n_outs, field, got, want);
    endtask

    // sender
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request(cur_req);
                void'(pending_reqs.pop_front());
                n_reqs++;
                case ($urandom_range(99)) inside
                    [0:59]: send_gap = 0;
                    [60:89]: send_gap = $urandom_range(3, 1);
                    [90:97]: send_gap = $urandom_range(15, 4);
                    default: send_gap = $urandom_range(60, 20);
                endcase
            end
            if (s_axis_tvalid && !s_axis_tready)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur_req = pending_reqs[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= cur_req.kind;
                s_axis_tdata <= {3'b0, cur_req.ref_neg, cur_req.started, cur_req.now_ms,
                                 cur_req.cap, cur_req.hall};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off once the run is under way
    int hold_left = 0;
    logic held_once = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (!held_once && n_reqs >= HOLD_AT)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                case ($urandom_range(99)) inside
                    [0:69]: m_axis_tready <= 1'b1;
                    [70:97]: m_axis_tready <= 1'b0;
                    default:
                    begin
                        hold_left = $urandom_range(50, 10);
                        m_axis_tready <= 1'b0;
                    end
                endcase
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        est_out_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_outs++;
            if (expected_outs.size() == 0)
            begin
                fails++;
                $display("unexpected result %0d: %h", n_outs, m_axis_tdata);
            end
            else
            begin
                w = expected_outs.pop_front();
                if (m_axis_tdata[15:0] !== w.angle_e)
                    report("angle_e", m_axis_tdata[15:0], w.angle_e);
                if (m_axis_tdata[31:16] !== w.rpm)
                    report("mech_speed_rpm", m_axis_tdata[31:16], w.rpm);
                if (m_axis_tdata[47:32] !== w.dpp)
                    report("speed_dpp", m_axis_tdata[47:32], w.dpp);
                if (m_axis_tdata[48] !== w.dir_neg)
                    report("direction_negative", m_axis_tdata[48], w.dir_neg);
                if (m_axis_tdata[49] !== w.valid)
                    report("valid_res", m_axis_tdata[49], w.valid);
                if (m_axis_tdata[57:50] !== w.errors)
                    report("error_count", m_axis_tdata[57:50], w.errors);
                if (m_axis_tdata[73:58] !== w.stalls)
                    report("stall_count", m_axis_tdata[73:58], w.stalls);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
            $display("** hall_sensor_angle_speed_core: FAILED **");
            $finish;
        end
    end

    task automatic add_req(input logic [2:0] kind, input logic [2:0] hall,
                           input logic [15:0] cap, input logic [31:0] now_ms,
                           input logic started, input logic ref_neg);
        hall_req_t r;
        r.kind = kind; r.hall = hall; r.cap = cap; r.now_ms = now_ms;
        r.started = started; r.ref_neg = ref_neg;
        pending_reqs.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            R_HALL_OFFSET: est_offset = int'(signed'(val[15:0]));
            R_MIN_PERIOD: est_min_per = val;
            R_MAX_PERIOD: est_max_per = val;
            R_DPP_FACTOR: est_dpp = val[30:0];
            R_COMP_DIV: est_comp_div = val[7:0];
            R_PWM_FREQ: est_pwm = val[15:0];
            R_POLE_PAIRS: est_poles = val[6:0];
            default: est_stall_tmo = val[15:0];
        endcase
    endtask

    task automatic wait_idle();
        wait (pending_reqs.size() == 0 && expected_outs.size() == 0);
        repeat (5) @(posedge clk);
    endtask

    // well-formed rotation with random timing, plus noise and stalls
    int rot_pos = 0;
    logic rot_rev = 1'b0;
    logic [31:0] clock_ms = '0;

    task automatic random_run(input int n);
        logic [2:0] h;
        logic [15:0] cap;
        for (int i = 0; i < n; i++)
        begin
            clock_ms += $urandom_range(20);
            case ($urandom_range(99)) inside
                [0:37]:
                begin
                    if ($urandom_range(19) == 0)
                        h = 3'($urandom_range(7));
                    else
                    begin
                        rot_pos = (rot_pos + (rot_rev ? 5 : 1)) % 6;
                        h = ROT[rot_pos];
                    end
                    cap = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(3000, 100));
                    add_req(K_EDGE, h, cap, clock_ms, 1'b0, 1'b0);
                end
                [38:57]: add_req(K_OVERFLOW, 3'($urandom), 16'($urandom), $urandom, 1'b0, 1'b0);
                [58:79]: add_req(K_ANGLE, 3'($urandom), 16'($urandom), $urandom, 1'b1, 1'b1);
                [80:91]:
                    add_req(K_SPEED, ROT[rot_pos], 16'($urandom), clock_ms,
                            $urandom_range(9) != 0, rot_rev ^ ($urandom_range(15) == 0));
                [92:95]:
                begin
                    if ($urandom_range(1))
                        rot_rev = ~rot_rev;
                    h = $urandom_range(7) == 0 ? 3'($urandom_range(7)) : ROT[rot_pos];
                    add_req(K_CLEAR, h, 16'($urandom), clock_ms, 1'b0, 1'b0);
                end
                [96:97]:
                    add_req(3'($urandom_range(K_SPARE_HI, K_SPARE_LO)), 3'($urandom),
                            16'($urandom), $urandom, 1'b1, 1'b1);
                default:
                begin
                    // long silence: speed task far in the future
                    clock_ms += $urandom;
                    add_req(K_SPEED, ROT[rot_pos], 16'($urandom), clock_ms, 1'b1, rot_rev);
                end
            endcase
        end
    endtask

    logic [31:0] phase_cfg [N_PHASES][8] = '{
        '{32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd16000, 32'd4, 32'd500},
        '{32'h7FFF, 32'd100, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd255, 32'd65535, 32'd1, 32'd65535},
        '{32'h8000, 32'd0, 32'd50000, 32'd20000000, 32'd8, 32'd1, 32'd127, 32'd1},
        '{32'd1234, 32'hFFFF_FFFF, 32'd0, 32'd1000000, 32'd0, 32'd0, 32'd0, 32'd100},
        '{32'hC000, 32'd300, 32'd1500, 32'd50000000, 32'd4, 32'd20000, 32'd7, 32'd2000},
        '{32'hEC78, 32'd0, 32'hFFFF_FFFF, 32'd3000000, 32'd16, 32'd16000, 32'd4, 32'd300}
    };

    initial
    begin
        est_reset();
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: rotation both ways, field extremes, bad hall states, lock-out
        add_req(K_CLEAR, 3'd5, 16'd0, 32'd0, 1'b0, 1'b0);
        add_req(K_EDGE, 3'd1, 16'd0, 32'd1, 1'b0, 1'b0);
        add_req(K_EDGE, 3'd3, 16'hFFFF, 32'd2, 1'b0, 1'b0);
        add_req(K_OVERFLOW, 3'd0, 16'd0, 32'd0, 1'b0, 1'b0);
        add_req(K_EDGE, 3'd2, 16'd0, 32'd3, 1'b0, 1'b0);
        add_req(K_ANGLE, 3'd0, 16'd0, 32'd0, 1'b0, 1'b0);
        add_req(K_SPEED, 3'd2, 16'd0, 32'd4, 1'b1, 1'b0);
        add_req(K_ANGLE, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        add_req(K_EDGE, HALL_BAD_LO, 16'd500, 32'd5, 1'b0, 1'b0);
        add_req(K_EDGE, HALL_BAD_HI, 16'd500, 32'd6, 1'b0, 1'b0);
        add_req(K_EDGE, 3'd3, 16'd800, 32'd7, 1'b0, 1'b0);
        add_req(K_EDGE, 3'd1, 16'd900, 32'd8, 1'b0, 1'b0);
        add_req(K_SPEED, 3'd1, 16'd0, 32'd9, 1'b1, 1'b0);
        add_req(K_SPEED, 3'd1, 16'd0, 32'd10, 1'b1, 1'b1);
        add_req(K_SPEED, 3'd4, 16'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_req(K_SPARE_LO, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        add_req(K_SPARE_HI, 3'd0, 16'd0, 32'd0, 1'b0, 1'b0);
        add_req(K_CLEAR, HALL_BAD_HI, 16'd0, 32'd20, 1'b0, 1'b0);
        add_req(K_ANGLE, 3'd0, 16'd0, 32'd0, 1'b0, 1'b0);
        add_req(K_SPEED, 3'd5, 16'd0, 32'd21, 1'b1, 1'b0);
        add_req(K_EDGE, 3'd4, 16'd100, 32'd22, 1'b0, 1'b0);
        add_req(K_CLEAR, 3'd4, 16'd0, 32'd23, 1'b0, 1'b0);
        rot_pos = 5;
        clock_ms = 32'd23;

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_idle();
            for (int r = 0; r < 8; r++)
                write_reg(CFG_AW'(r), phase_cfg[ph][r]);
            @(posedge clk);
            cfg_we <= 1'b0;
            @(posedge clk);
            add_req(K_CLEAR, ROT[rot_pos], 16'd0, clock_ms, 1'b0, 1'b0);
            random_run(RUN_ITEMS);
        end

        wait (pending_reqs.size() == 0 && expected_outs.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("%0d requests sent over %0d register settings, %0d results checked",
                 n_reqs, N_PHASES + 1, n_outs);
        $display("%0d hall edges, %0d speed tasks, %0d stalls in the final count",
                 n_edges, n_speed, est_stalls);
        if (fails == 0)
            $display("** hall_sensor_angle_speed_core: PASSED **");
        else
            $display("** hall_sensor_angle_speed_core: FAILED **");
        $finish;
    end

endmodule

/* hall_sensor_angle_speed_core.f */
hdl/hsa_pkg.sv
hdl/hsa_div.sv
hdl/hall_sensor_angle_speed_core.sv
dv/tb_hall_sensor_angle_speed_core.sv
